@@ rtl/core/cau_pkg.sv @@
// Package for the complex arithmetic unit: opcodes, widths, helpers.
// No dependencies.
package cau_pkg;

   localparam int unsigned DW      = 16;
   localparam int unsigned PW      = 33;   // product sum width
   localparam int unsigned NW      = 45;   // dividend magnitude width (n * 4096)
   localparam int unsigned DVW     = 32;   // divisor width
   localparam int unsigned QW      = 17;   // quotient bits kept (saturation aware)
   localparam int unsigned FRAC    = 12;
   localparam int unsigned DIV_LAT = QW + 1;   // range check, then one stage per bit

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       dz;
   } ctl_type;

   function automatic logic [DW:0] sat16(input logic signed [PW+FRAC:0] v);
      logic [DW:0] r;
      if (v > 46'sd32767)
         r = {1'b1, 16'h7fff};
      else if (v < -46'sd32768)
         r = {1'b1, 16'h8000};
      else
         r = {1'b0, v[DW-1:0]};
      return r;
   endfunction

endpackage

@@ rtl/core/cau_div.sv @@
// Pipelined restoring divider: unsigned NW-bit dividend over DVW-bit divisor.
// Range-check stage, then one quotient bit per stage. Uses cau_pkg.
module cau_div (
   input  logic                    clock,
   input  logic [cau_pkg::NW-1:0]  num,
   input  logic [cau_pkg::DVW-1:0] den,
   output logic [cau_pkg::QW:0]    quo
);
   localparam int unsigned NW  = cau_pkg::NW;
   localparam int unsigned DVW = cau_pkg::DVW;
   localparam int unsigned QW  = cau_pkg::QW;
   localparam int unsigned HI  = NW - QW;         // dividend bits above the quotient window
   localparam int unsigned LW  = DVW + QW;

   // quotient at or above 2**QW saturates
   logic [LW-1:0] lim;
   assign lim = {{QW{1'b0}}, den} << QW;

   logic [DVW:0]   rem_ff [QW+1];
   logic [QW-1:0]  low_ff [QW+1];
   logic [DVW-1:0] dv_ff  [QW+1];
   logic [QW-1:0]  q_ff   [QW+1];
   logic           big_ff [QW+1];

   logic [DVW+1:0] part_in [QW];
   logic [DVW+1:0] diff_in [QW];

   always_comb begin
      for (int s = 0; s < QW; s++) begin
         part_in[s] = {rem_ff[s], low_ff[s][QW-1]};
         diff_in[s] = part_in[s] - {2'b00, dv_ff[s]};
      end
   end

   always_ff @(posedge clock) begin
      big_ff[0] <= {{(LW-NW){1'b0}}, num} >= lim;
      rem_ff[0] <= {{(DVW+1-HI){1'b0}}, num[NW-1 -: HI]};
      low_ff[0] <= num[QW-1:0];
      dv_ff[0]  <= den;
      q_ff[0]   <= '0;
      for (int s = 0; s < QW; s++) begin
         rem_ff[s+1] <= diff_in[s][DVW+1] ? part_in[s][DVW:0] : diff_in[s][DVW:0];
         low_ff[s+1] <= {low_ff[s][QW-2:0], 1'b0};
         dv_ff[s+1]  <= dv_ff[s];
         q_ff[s+1]   <= {q_ff[s][QW-2:0], ~diff_in[s][DVW+1]};
         big_ff[s+1] <= big_ff[s];
      end
   end

   assign quo = big_ff[QW] ? '1 : {1'b0, q_ff[QW]};
endmodule

@@ rtl/core/complex_arithmetic_unit_top.sv @@
// Complex arithmetic unit top level: add, subtract, multiply, divide in Q4.12.
// Uses cau_pkg and cau_div.
//
// Usage: drive req_* with start high; busy is always low, so a word is taken
// every cycle. Each word yields one result word, shown for one cycle with
// rsp_valid high as it leaves the output register, whatever the opcode, so
// words leave in order. Throughput is one word per clock. The pipeline is one
// stage of products, one of sums, the divider (a range-check stage, then one
// quotient bit per stage, 18 in all) and the output register.
// The receiver cannot stall; none is needed since the pipeline never waits.
// Reset clears the valid bits only: words in flight are dropped.
module complex_arithmetic_unit_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic signed [15:0] req_a_re,
   input  logic signed [15:0] req_a_im,
   input  logic signed [15:0] req_b_re,
   input  logic signed [15:0] req_b_im,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_res_re,
   output logic signed [15:0] rsp_res_im,
   output logic               rsp_overflow,
   output logic               rsp_div_zero
);
   localparam int unsigned PW  = cau_pkg::PW;
   localparam int unsigned NW  = cau_pkg::NW;
   localparam int unsigned QW  = cau_pkg::QW;
   localparam int unsigned DL  = cau_pkg::DIV_LAT;  // divider latency
   localparam int unsigned LAT = DL + 2;

   assign busy = 1'b0;

   // stage 1: products
   logic signed [31:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff;
   logic signed [16:0] s_re_ff, s_im_ff;
   logic               v1_ff;
   cau_pkg::ctl_type   c1_ff;
   always_ff @(posedge clock) begin
      p_rr_ff <= req_a_re * req_b_re;
      p_ii_ff <= req_a_im * req_b_im;
      p_ir_ff <= req_a_im * req_b_re;
      p_ri_ff <= req_a_re * req_b_im;
      s_re_ff <= (req_cmd == cau_pkg::CMD_SUB) ? 17'(req_a_re) - 17'(req_b_re)
                                               : 17'(req_a_re) + 17'(req_b_re);
      s_im_ff <= (req_cmd == cau_pkg::CMD_SUB) ? 17'(req_a_im) - 17'(req_b_im)
                                               : 17'(req_a_im) + 17'(req_b_im);
      c1_ff.cmd <= req_cmd;
      c1_ff.dz  <= (req_b_re == 16'sd0) && (req_b_im == 16'sd0);
   end
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= start;
   end

   // stage 2: sums
   logic signed [PW-1:0] n_re_ff, n_im_ff;
   logic signed [16:0]   s2_re_ff, s2_im_ff;
   cau_pkg::ctl_type     c2_ff;
   always_ff @(posedge clock) begin
      if (c1_ff.cmd == cau_pkg::CMD_DIV) begin
         n_re_ff <= PW'(p_rr_ff) + PW'(p_ii_ff);
         n_im_ff <= PW'(p_ir_ff) - PW'(p_ri_ff);
      end else begin
         n_re_ff <= PW'(p_rr_ff) - PW'(p_ii_ff);
         n_im_ff <= PW'(p_ir_ff) + PW'(p_ri_ff);
      end
      s2_re_ff <= s_re_ff;
      s2_im_ff <= s_im_ff;
      c2_ff    <= c1_ff;
   end
   // |b|^2 from squares: separate registers
   logic signed [31:0] sq_r_ff, sq_i_ff;
   always_ff @(posedge clock) begin
      sq_r_ff <= req_b_re * req_b_re;
      sq_i_ff <= req_b_im * req_b_im;
   end
   logic [31:0] den_ff;
   always_ff @(posedge clock) begin
      den_ff <= sq_r_ff + sq_i_ff;
   end

   // stage 3: magnitudes into divider, mul/add/sub results held in delay line
   logic [NW-1:0] mr, mi;
   assign mr = n_re_ff[PW-1] ? NW'(-n_re_ff) << cau_pkg::FRAC : NW'(n_re_ff) << cau_pkg::FRAC;
   assign mi = n_im_ff[PW-1] ? NW'(-n_im_ff) << cau_pkg::FRAC : NW'(n_im_ff) << cau_pkg::FRAC;
   logic [QW:0] q_re, q_im;
   logic [31:0] den_safe;
   assign den_safe = (den_ff == 32'd0) ? 32'd1 : den_ff;

   cau_div u_div_re (.clock(clock), .num(mr), .den(den_safe), .quo(q_re));
   cau_div u_div_im (.clock(clock), .num(mi), .den(den_safe), .quo(q_im));

   logic [16:0] r_re, r_im;
   always_comb begin
      r_re = cau_pkg::sat16(46'(n_re_ff) >>> cau_pkg::FRAC);
      r_im = cau_pkg::sat16(46'(n_im_ff) >>> cau_pkg::FRAC);
      // truncate toward zero
      if (n_re_ff[PW-1] && (n_re_ff[11:0] != 12'd0))
         r_re = cau_pkg::sat16((46'(n_re_ff) >>> cau_pkg::FRAC) + 46'sd1);
      if (n_im_ff[PW-1] && (n_im_ff[11:0] != 12'd0))
         r_im = cau_pkg::sat16((46'(n_im_ff) >>> cau_pkg::FRAC) + 46'sd1);
      if (c2_ff.cmd == cau_pkg::CMD_ADD || c2_ff.cmd == cau_pkg::CMD_SUB) begin
         r_re = cau_pkg::sat16(46'(s2_re_ff));
         r_im = cau_pkg::sat16(46'(s2_im_ff));
      end
   end

   typedef struct packed {
      logic [16:0]      re;
      logic [16:0]      im;
      logic             nr;
      logic             ni;
      cau_pkg::ctl_type c;
   } dly_type;
   dly_type dl_ff [DL];
   logic    vl_ff [LAT];
   always_ff @(posedge clock) begin
      dl_ff[0] <= '{re: r_re, im: r_im, nr: n_re_ff[PW-1], ni: n_im_ff[PW-1], c: c2_ff};
      for (int i = 1; i < DL; i++) dl_ff[i] <= dl_ff[i-1];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vl_ff[i] <= 1'b0;
      end else begin
         vl_ff[0] <= v1_ff;
         for (int i = 1; i < LAT; i++) vl_ff[i] <= vl_ff[i-1];
      end
   end

   // output stage
   logic signed [QW+1:0] dq_re, dq_im;
   logic [16:0]          o_re, o_im;
   dly_type              t;
   always_comb begin
      t     = dl_ff[DL-1];
      dq_re = t.nr ? -$signed({1'b0, q_re}) : $signed({1'b0, q_re});
      dq_im = t.ni ? -$signed({1'b0, q_im}) : $signed({1'b0, q_im});
      o_re  = cau_pkg::sat16(46'(dq_re));
      o_im  = cau_pkg::sat16(46'(dq_im));
   end

   logic signed [15:0] ro_re_ff, ro_im_ff;
   logic               ro_ov_ff, ro_dz_ff;
   always_ff @(posedge clock) begin
      unique case (cau_pkg::cmd_type'(t.c.cmd))
         cau_pkg::CMD_DIV: begin
            if (t.c.dz) begin
               ro_re_ff <= '0;
               ro_im_ff <= '0;
               ro_ov_ff <= 1'b0;
               ro_dz_ff <= 1'b1;
            end else begin
               ro_re_ff <= o_re[15:0];
               ro_im_ff <= o_im[15:0];
               ro_ov_ff <= o_re[16] | o_im[16];
               ro_dz_ff <= 1'b0;
            end
         end
         default: begin
            ro_re_ff <= t.re[15:0];
            ro_im_ff <= t.im[15:0];
            ro_ov_ff <= t.re[16] | t.im[16];
            ro_dz_ff <= 1'b0;
         end
      endcase
   end

   assign rsp_valid    = vl_ff[LAT-1];
   assign rsp_res_re   = ro_re_ff;
   assign rsp_res_im   = ro_im_ff;
   assign rsp_overflow = ro_ov_ff;
   assign rsp_div_zero = ro_dz_ff;
endmodule

@@ rtl/core/cau_checker.sv @@
// Port checker for the complex arithmetic unit, bound to the top level.
// Depends on complex_arithmetic_unit_top ports only.
module cau_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_overflow,
   input logic        rsp_div_zero,
   input logic [15:0] rsp_res_re,
   input logic [15:0] rsp_res_im
);
   a_never_busy: assert property (@(posedge clock) !busy) else $error("busy");
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero |-> rsp_res_re == 16'd0 && rsp_res_im == 16'd0)
      else $error("div_zero result not zero");
   a_dz_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero |-> !rsp_overflow) else $error("dz with overflow");
   a_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("valid after reset");
endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (.*);

@@ dv/tb_top.sv @@
// Self-checking testbench for complex_arithmetic_unit_top: directed and random
// Q4.12 add/sub/mul/div words checked against an in-bench predictor.
// Depends on cau_pkg and the RTL of the unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               ovf;
      logic               dz;
   } res_type;

   class scoreboard_type;
      res_type pending[$];
      int      mismatches;
      int      failures;

      function logic signed [15:0] clamp(longint v, inout logic ovf);
         if (v > 32767) begin
            ovf = 1'b1;
            return 16'sh7fff;
         end
         if (v < -32768) begin
            ovf = 1'b1;
            return 16'sh8000;
         end
         return v[15:0];
      endfunction

      function void note_word(cau_pkg::cmd_type op, logic signed [15:0] ar,
                              logic signed [15:0] ai, logic signed [15:0] br,
                              logic signed [15:0] bi);
         longint  xr, xi, den;
         res_type r;
         logic    ovf;
         ovf  = 1'b0;
         r.dz = 1'b0;
         xr = 0;
         xi = 0;
         case (op)
            cau_pkg::CMD_ADD: begin
               xr = longint'(ar) + br;
               xi = longint'(ai) + bi;
            end
            cau_pkg::CMD_SUB: begin
               xr = longint'(ar) - br;
               xi = longint'(ai) - bi;
            end
            cau_pkg::CMD_MUL: begin
               xr = (longint'(ar) * br - longint'(ai) * bi) / 4096;
               xi = (longint'(ai) * br + longint'(ar) * bi) / 4096;
            end
            default: begin
               den = longint'(br) * br + longint'(bi) * bi;
               if (den == 0)
                  r.dz = 1'b1;
               else begin
                  xr = ((longint'(ar) * br + longint'(ai) * bi) * 4096) / den;
                  xi = ((longint'(ai) * br - longint'(ar) * bi) * 4096) / den;
               end
            end
         endcase
         r.re  = clamp(xr, ovf);
         r.im  = clamp(xi, ovf);
         r.ovf = ovf;
         pending = {pending, r};
      endfunction

      function void check_word(logic signed [15:0] re, logic signed [15:0] im,
                               logic ovf, logic dz);
         res_type e;
         if (pending.size() == 0) begin
            failures++;
            if (mismatches++ < 10)
               $display("unexpected result word re=%0d im=%0d", re, im);
            return;
         end
         e = pending.pop_front();
         if (re !== e.re || im !== e.im || ovf !== e.ovf || dz !== e.dz) begin
            failures++;
            if (mismatches++ < 10)
               $display("mismatch: exp %0d %0d ovf=%b dz=%b, got %0d %0d ovf=%b dz=%b",
                        e.re, e.im, e.ovf, e.dz, re, im, ovf, dz);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_cmd = '0;
   logic signed [15:0] req_a_re = '0, req_a_im = '0, req_b_re = '0, req_b_im = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_res_re, rsp_res_im;
   logic               rsp_overflow, rsp_div_zero;

   scoreboard_type sb = new();
   int unsigned    cycles = 0;
   int unsigned    idle_left = 0;
   bit             idling_on = 1'b1;

   complex_arithmetic_unit_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid)
         sb.check_word(rsp_res_re, rsp_res_im, rsp_overflow, rsp_div_zero);
      if (cycles > 200000) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic signed [15:0] pick_val();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sd0;
         3: return 16'($urandom_range(0, 8191) - 4096);
         4: return 16'($urandom_range(0, 255) - 128);
         default: return 16'($urandom());
      endcase
   endfunction

   // one word; start stays high across back-to-back words
   task automatic send_word(cau_pkg::cmd_type op, logic signed [15:0] ar,
                            logic signed [15:0] ai, logic signed [15:0] br,
                            logic signed [15:0] bi);
      if (idling_on && idle_left == 0 && $urandom_range(0, 3) == 0)
         idle_left = $urandom_range(1, 8);
      while (idle_left > 0) begin
         start <= 1'b0;
         @(posedge clock);
         idle_left--;
      end
      start    <= 1'b1;
      req_cmd  <= op;
      req_a_re <= ar;
      req_a_im <= ai;
      req_b_re <= br;
      req_b_im <= bi;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_word(op, ar, ai, br, bi);
   endtask

   task automatic drain();
      int unsigned n;
      n = 0;
      start <= 1'b0;
      while (sb.pending.size() != 0 && n < 1000) begin
         @(posedge clock);
         n++;
      end
   endtask

   initial begin
      logic signed [15:0] ext[4];
      ext = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd4096};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int c = 0; c < 4; c++) begin
         send_word(cau_pkg::cmd_type'(c), 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff);
         send_word(cau_pkg::cmd_type'(c), 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000);
         send_word(cau_pkg::cmd_type'(c), 16'sd4096, 16'sd0, 16'sd0, 16'sd0);
         send_word(cau_pkg::cmd_type'(c), 16'sh8000, 16'sh8000, 16'sd1, 16'sd0);
      end
      send_word(cau_pkg::CMD_DIV, 16'sh8000, 16'sh8000, 16'sd0, 16'sd1);
      send_word(cau_pkg::CMD_DIV, 16'sd1, 16'sd1, 16'sd3, 16'sd0);
      send_word(cau_pkg::CMD_DIV, -16'sd7, 16'sd5, -16'sd3, 16'sd2);
      send_word(cau_pkg::CMD_DIV, 16'sh7fff, 16'sd0, 16'sh8000, 16'sd0);
      drain();
      for (int i = 0; i < 450; i++) begin
         if (i == 380) idling_on = 1'b0;
         if (i == 200) drain();
         if ($urandom_range(0, 3) == 0)
            send_word(cau_pkg::cmd_type'($urandom_range(0, 3)), ext[$urandom_range(0, 3)],
                      ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)],
                      ext[$urandom_range(0, 3)]);
         else
            send_word(cau_pkg::cmd_type'($urandom_range(0, 3)), pick_val(), pick_val(),
                      pick_val(), pick_val());
      end
      drain();
      repeat (30) @(posedge clock);
      if (sb.failures == 0 && sb.pending.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/core/cau_pkg.sv
rtl/core/cau_div.sv
rtl/core/complex_arithmetic_unit_top.sv
rtl/core/cau_checker.sv
dv/tb_top.sv
